### hw/rtl/bba_pkg.sv
// shared types and constants of the buddy block allocator
package bba_pkg;

  localparam int UNIT_W  = 16;   // one unit per 16-byte minimum block
  localparam int LINK_W  = 17;   // unit plus one, zero for none
  localparam int LVL_W   = 5;
  localparam int SIZE_W  = 21;
  localparam int ADDR_W  = 20;
  localparam int LEVELS  = 17;
  localparam int REC_W   = 1 + LVL_W + SIZE_W;

  localparam logic [1:0] CMD_ALLOC  = 2'd0;
  localparam logic [1:0] CMD_FREE   = 2'd1;
  localparam logic [1:0] CMD_RESIZE = 2'd2;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_OOM = 2'd1;
  localparam logic [1:0] ST_BAD = 2'd2;

  localparam logic [SIZE_W-1:0] POOL_MAX = 21'h100000;

  typedef struct packed {
    logic              used;
    logic [LVL_W-1:0]  lvl;
    logic [SIZE_W-1:0] size;
  } rec_t;

endpackage

### hw/rtl/bba_ram.sv
// single-port-write, registered-read memory
module bba_ram #(
  parameter int DW = 27,
  parameter int AW = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [0:(1<<AW)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/buddy_block_allocator_core.sv
// top level: buddy allocator sequencer over record and free-list link memories
//
// Buddy allocator over a pool of up to 1 MiB, carved into power-of-two blocks of
// 16 << level bytes, each with an 8-byte header; addresses on the ports are payload
// offsets (block start plus 8). Requests come on the slave stream: tuser holds the
// command (allocate, free, resize), tdata the requested size and the block address.
// Each request not cut off by a config write gets one m_tdata reply: status, address,
// moved flag and pool statistics. A relocating resize only reports moved; the copy
// is left to software. Writing pool_bytes on the config channel lays the pool out
// again and drops every allocation. After reset or a config write the block sweeps
// its three 64K-entry memories, then carves the pool level by level, largest first,
// and accepts no request meanwhile. One request is handled at a time; its length is
// set by the serialized read-modify-write accesses to the record and link memories.
// An address out of range is rejected at decode, one not naming a used block once its
// record is read; a resize within its size class rewrites the record in place. An
// allocate searches the levels upward from the size class, unlinks the block found and
// splits it down, pushing each upper half on a free list; a free merges with its buddy
// level by level, then inserts the block in a free list; a relocating resize does both.
// The response waits for the master stream; the next request is accepted only in idle.
module buddy_block_allocator_core
  import bba_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // request_size[20:0], block_addr[40:21], zero pad
  input  logic [1:0]  s_tuser,   // cmd[1:0]
  // response stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // status[1:0], addr[21:2], moved[22], free_bytes[43:23],
                                 // requested_bytes[64:44], largest_free[84:65], zero pad
  // pool size register
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [20:0] cfg_data
);

  // sequencer states
  localparam logic [4:0] S_CLEAR    = 5'd0;
  localparam logic [4:0] S_CARVE    = 5'd1;
  localparam logic [4:0] S_IDLE     = 5'd2;
  localparam logic [4:0] S_DEC      = 5'd3;
  localparam logic [4:0] S_VCHK     = 5'd4;
  localparam logic [4:0] S_FR_START = 5'd5;
  localparam logic [4:0] S_FB_A     = 5'd6;
  localparam logic [4:0] S_FB_B     = 5'd7;
  localparam logic [4:0] S_FM       = 5'd8;
  localparam logic [4:0] S_FM_B     = 5'd9;
  localparam logic [4:0] S_PUSH_A   = 5'd10;
  localparam logic [4:0] S_PUSH_B   = 5'd11;
  localparam logic [4:0] S_DEL_A    = 5'd12;
  localparam logic [4:0] S_DEL_B    = 5'd13;
  localparam logic [4:0] S_AL_SRCH  = 5'd14;
  localparam logic [4:0] S_AL_SPLIT = 5'd15;
  localparam logic [4:0] S_AL_OK    = 5'd16;
  localparam logic [4:0] S_AL_FAIL  = 5'd17;
  localparam logic [4:0] S_RS       = 5'd18;
  localparam logic [4:0] S_RS_GB    = 5'd19;
  localparam logic [4:0] S_RS_GW    = 5'd20;
  localparam logic [4:0] S_RS_SHR   = 5'd21;
  localparam logic [4:0] S_RS_MOVE  = 5'd22;
  localparam logic [4:0] S_FIN      = 5'd23;

  logic [4:0]        state;
  logic [4:0]        ret;          // return state of the list push/delete subroutines

  // request
  logic [1:0]        cmd;
  logic [SIZE_W-1:0] rsize;
  logic [ADDR_W-1:0] baddr;

  // pool state
  logic [SIZE_W-1:0] pool_bytes;
  logic [LINK_W-1:0] head [0:LEVELS-1];
  logic [LVL_W-1:0]  lc;           // level count
  logic [SIZE_W-1:0] capb;         // laid-out capacity in bytes
  logic [SIZE_W-1:0] freet;
  logic [SIZE_W-1:0] reqt;

  // layout
  logic [LINK_W-1:0] clr;
  logic [LVL_W-1:0]  cl;
  logic [LINK_W-1:0] off;
  logic              found;

  // working registers
  logic [UNIT_W-1:0] u, fu, fbu, au, pu, du;
  logic [LVL_W-1:0]  olvl, flvl, ai, alvl, rl, pl, dl;
  logic [SIZE_W-1:0] osize;
  logic [21:0]       rhalf;
  logic [1:0]        st;
  logic [ADDR_W-1:0] raddr_res;
  logic              moved;

  // memory ports
  logic              rec_we, prv_we, nxt_we;
  logic [UNIT_W-1:0] rec_wa, prv_wa, nxt_wa, rec_ra, lnk_ra;
  logic [REC_W-1:0]  rec_wd, rec_rd;
  logic [LINK_W-1:0] prv_wd, nxt_wd, prv_rd, nxt_rd;
  rec_t              rrec;

  assign rrec = rec_t'(rec_rd);

  bba_ram #(.DW(REC_W), .AW(UNIT_W)) u_rec (
    .clk(clk), .we(rec_we), .waddr(rec_wa), .wdata(rec_wd), .raddr(rec_ra), .rdata(rec_rd)
  );
  bba_ram #(.DW(LINK_W), .AW(UNIT_W)) u_prv (
    .clk(clk), .we(prv_we), .waddr(prv_wa), .wdata(prv_wd), .raddr(lnk_ra), .rdata(prv_rd)
  );
  bba_ram #(.DW(LINK_W), .AW(UNIT_W)) u_nxt (
    .clk(clk), .we(nxt_we), .waddr(nxt_wa), .wdata(nxt_wd), .raddr(lnk_ra), .rdata(nxt_rd)
  );

  // clamped pool size
  logic [SIZE_W-1:0] pbc;
  assign pbc = (pool_bytes > POOL_MAX) ? POOL_MAX : pool_bytes;

  // smallest level that holds the request plus header
  logic [21:0]      need_m1;
  logic [LVL_W-1:0] alvl_c;
  always_comb begin
    need_m1 = (rsize == '0) ? 22'd15 : ({1'b0, rsize} + 22'd7);
    alvl_c  = '0;
    for (int k = 0; k < LEVELS; k++) begin
      if ((need_m1 >> (k + 4)) != 22'd0) begin
        alvl_c = LVL_W'(k + 1);
      end
    end
  end

  // payload address check
  logic [ADDR_W-1:0] boff;
  logic              bvalid;
  assign boff   = baddr - ADDR_W'(8);
  assign bvalid = (baddr >= ADDR_W'(8)) && (boff[3:0] == 4'd0) &&
                  ({1'b0, boff} < capb);

  // buddy of a block, shared by free and resize
  logic [UNIT_W-1:0] bsel_u, bu_c;
  logic [LVL_W-1:0]  bsel_l;
  logic [18:0]       bsu, bub, bb;
  logic              bok;
  always_comb begin
    bsel_u = (state == S_RS) ? u : fu;
    bsel_l = (state == S_RS) ? olvl : flvl;
    bsu    = 19'd1 << bsel_l;
    bub    = {3'b000, bsel_u};
    if ((bub & bsu) != 19'd0) begin
      bb  = bub - bsu;
      bok = 1'b1;
    end else begin
      bb  = bub + bsu;
      bok = (bb + bsu) <= {2'b00, capb[20:4]};
    end
    bu_c = bb[UNIT_W-1:0];
  end

  // resize size classes
  logic [21:0] asize, capr, halfr, cap2;
  assign asize = {1'b0, rsize} + 22'd8;
  assign capr  = 22'd16 << olvl;
  assign halfr = capr >> 1;
  assign cap2  = capr << 1;

  logic [SIZE_W-1:0] req_rs;
  assign req_rs = reqt - osize + rsize;

  // largest free payload
  logic [ADDR_W-1:0] largest;
  always_comb begin
    largest = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if (head[i] != '0) begin
        largest = ADDR_W'((21'd16 << i) - 21'd8);
      end
    end
  end

  logic [UNIT_W-1:0] umin;
  assign umin = (fbu < fu) ? fbu : fu;

  // memory port steering
  always_comb begin
    rec_we = 1'b0; rec_wa = u;  rec_wd = '0; rec_ra = u;
    prv_we = 1'b0; prv_wa = pu; prv_wd = '0;
    nxt_we = 1'b0; nxt_wa = pu; nxt_wd = '0;
    lnk_ra = du;
    case (state)
      S_CLEAR: begin
        rec_we = 1'b1; rec_wa = clr[UNIT_W-1:0];
        prv_we = 1'b1; prv_wa = clr[UNIT_W-1:0];
        nxt_we = 1'b1; nxt_wa = clr[UNIT_W-1:0];
      end
      S_CARVE: begin
        rec_we = pbc[cl + 5'd4];
        rec_wa = off[UNIT_W-1:0];
        rec_wd = REC_W'({1'b0, cl, {SIZE_W{1'b0}}});
      end
      S_DEC:      rec_ra = boff[19:4];
      S_FR_START: begin
        rec_we = 1'b1;
        rec_wd = REC_W'({1'b0, olvl, osize});
      end
      S_FB_A:     rec_ra = bu_c;
      S_FM:       rec_ra = umin;
      S_FM_B: begin
        rec_we = 1'b1; rec_wa = fu;
        rec_wd = REC_W'({1'b0, flvl, rrec.size});
      end
      S_PUSH_A: begin
        rec_ra = pu;
        nxt_we = 1'b1; nxt_wa = pu; nxt_wd = head[pl];
        prv_we = 1'b1; prv_wa = pu; prv_wd = '0;
      end
      S_PUSH_B: begin
        rec_we = 1'b1; rec_wa = pu;
        rec_wd = REC_W'({1'b0, pl, rrec.size});
        prv_we = (head[pl] != '0);
        prv_wa = UNIT_W'(head[pl] - LINK_W'(1));
        prv_wd = {1'b0, pu} + LINK_W'(1);
      end
      S_DEL_B: begin
        nxt_we = (prv_rd != '0);
        nxt_wa = UNIT_W'(prv_rd - LINK_W'(1));
        nxt_wd = nxt_rd;
        prv_we = (nxt_rd != '0);
        prv_wa = UNIT_W'(nxt_rd - LINK_W'(1));
        prv_wd = prv_rd;
      end
      S_AL_SPLIT: begin
        rec_we = (ai <= alvl); rec_wa = au;
        rec_wd = REC_W'({1'b1, alvl, rsize});
      end
      S_RS: begin
        rec_we = (halfr < asize) && (asize <= capr);
        rec_wd = REC_W'({1'b1, olvl, rsize});
        rec_ra = bu_c;
      end
      S_RS_GW: begin
        rec_we = 1'b1;
        rec_wd = REC_W'({1'b1, olvl + 5'd1, rsize});
      end
      S_RS_SHR: begin
        rec_we = !((rl != '0) && (rhalf >= asize));
        rec_wd = REC_W'({1'b1, rl, rsize});
      end
      default: ;
    endcase
  end

  // a pool write takes priority, so no request is taken in the same cycle
  assign s_tready  = (state == S_IDLE) && !cfg_valid;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      pool_bytes <= POOL_MAX;
      clr        <= '0;
      m_tvalid   <= 1'b0;
      for (int i = 0; i < LEVELS; i++) head[i] <= '0;
    end else if (cfg_valid) begin
      // new pool size: lay the pool out again
      state      <= S_CLEAR;
      pool_bytes <= cfg_data;
      clr        <= '0;
      for (int i = 0; i < LEVELS; i++) head[i] <= '0;
    end else begin
      if (m_tvalid && m_tready && state != S_FIN) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr <= clr + LINK_W'(1);
          if (clr[UNIT_W-1:0] == '1) begin
            state <= S_CARVE;
            cl    <= LVL_W'(LEVELS - 1);
            off   <= '0;
            found <= 1'b0;
            lc    <= LVL_W'(1);
          end
        end
        // one level per cycle, largest first
        S_CARVE: begin
          if (pbc[cl + 5'd4]) begin
            head[cl] <= off + LINK_W'(1);
            off      <= off + (LINK_W'(1) << cl);
            if (!found) begin
              found <= 1'b1;
              lc    <= cl + 5'd1;
            end
          end
          if (cl == '0) begin
            capb  <= {pbc[20:4], 4'd0};
            freet <= {pbc[20:4], 4'd0};
            reqt  <= '0;
            state <= S_IDLE;
          end else begin
            cl <= cl - 5'd1;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            cmd       <= s_tuser;
            rsize     <= s_tdata[20:0];
            baddr     <= s_tdata[40:21];
            st        <= ST_OK;
            raddr_res <= '0;
            moved     <= 1'b0;
            state     <= S_DEC;
          end
        end
        S_DEC: begin
          alvl <= alvl_c;
          ai   <= alvl_c;
          u    <= boff[19:4];
          if (cmd == CMD_ALLOC) begin
            state <= S_AL_SRCH;
          end else if (cmd == CMD_FREE || cmd == CMD_RESIZE) begin
            if (bvalid) begin
              state <= S_VCHK;
            end else begin
              st    <= ST_BAD;
              state <= S_FIN;
            end
          end else begin
            state <= S_FIN;
          end
        end
        S_VCHK: begin
          olvl  <= rrec.lvl;
          osize <= rrec.size;
          if (!rrec.used) begin
            st    <= ST_BAD;
            state <= S_FIN;
          end else if (cmd == CMD_FREE || rsize == '0) begin
            state <= S_FR_START;
          end else begin
            state <= S_RS;
          end
        end
        // free: account, mark free, then merge upward
        S_FR_START: begin
          fu    <= u;
          flvl  <= olvl;
          reqt  <= reqt - osize;
          freet <= freet + (21'd16 << olvl);
          state <= S_FB_A;
        end
        S_FB_A: begin
          fbu <= bu_c;
          if (bok) begin
            state <= S_FB_B;
          end else begin
            pu    <= fu;
            pl    <= flvl;
            ret   <= S_FIN;
            state <= S_PUSH_A;
          end
        end
        S_FB_B: begin
          if (!rrec.used && rrec.lvl == flvl) begin
            du    <= fbu;
            dl    <= flvl;
            ret   <= S_FM;
            state <= S_DEL_A;
          end else begin
            pu    <= fu;
            pl    <= flvl;
            ret   <= S_FIN;
            state <= S_PUSH_A;
          end
        end
        S_FM: begin
          fu    <= umin;
          flvl  <= flvl + 5'd1;
          state <= S_FM_B;
        end
        S_FM_B:   state <= S_FB_A;
        // list push: link in, then record and old head
        S_PUSH_A: state <= S_PUSH_B;
        S_PUSH_B: begin
          head[pl] <= {1'b0, pu} + LINK_W'(1);
          state    <= ret;
        end
        // list delete: read links, then patch neighbors
        S_DEL_A:  state <= S_DEL_B;
        S_DEL_B: begin
          if (prv_rd == '0) begin
            head[dl] <= nxt_rd;
          end
          state <= ret;
        end
        // allocate: find first non-empty level at or above the size class
        S_AL_SRCH: begin
          if (ai >= lc) begin
            state <= S_AL_FAIL;
          end else if (head[ai] != '0) begin
            au    <= UNIT_W'(head[ai] - LINK_W'(1));
            du    <= UNIT_W'(head[ai] - LINK_W'(1));
            dl    <= ai;
            ret   <= S_AL_SPLIT;
            state <= S_DEL_A;
          end else begin
            ai <= ai + 5'd1;
          end
        end
        S_AL_SPLIT: begin
          if (ai > alvl) begin
            ai    <= ai - 5'd1;
            pu    <= au + (UNIT_W'(1) << (ai - 5'd1));
            pl    <= ai - 5'd1;
            ret   <= S_AL_SPLIT;
            state <= S_PUSH_A;
          end else begin
            reqt      <= reqt + rsize;
            freet     <= freet - (21'd16 << alvl);
            raddr_res <= {au, 4'b1000};
            state     <= S_AL_OK;
          end
        end
        S_AL_OK: begin
          if (cmd == CMD_ALLOC) begin
            state <= S_FIN;
          end else begin
            // relocating resize: release the old block
            moved <= 1'b1;
            state <= S_FR_START;
          end
        end
        S_AL_FAIL: begin
          st        <= ST_OOM;
          raddr_res <= '0;
          state     <= S_FIN;
        end
        // resize: same class, grow into upper buddy, shrink, or move
        S_RS: begin
          raddr_res <= {u, 4'b1000};
          fbu       <= bu_c;
          if ((halfr < asize) && (asize <= capr)) begin
            reqt  <= req_rs;
            state <= S_FIN;
          end else if ((capr < asize) && (asize <= cap2)) begin
            state <= bok ? S_RS_GB : S_RS_MOVE;
          end else if (asize <= halfr) begin
            reqt  <= req_rs;
            rl    <= olvl;
            rhalf <= halfr;
            state <= S_RS_SHR;
          end else begin
            state <= S_RS_MOVE;
          end
        end
        S_RS_GB: begin
          if (!rrec.used && rrec.lvl == olvl && fbu > u) begin
            reqt  <= req_rs;
            freet <= freet - capr[20:0];
            du    <= fbu;
            dl    <= olvl;
            ret   <= S_RS_GW;
            state <= S_DEL_A;
          end else begin
            state <= S_RS_MOVE;
          end
        end
        S_RS_GW:  state <= S_FIN;
        S_RS_SHR: begin
          if ((rl != '0) && (rhalf >= asize)) begin
            freet <= freet + rhalf[20:0];
            rl    <= rl - 5'd1;
            rhalf <= rhalf >> 1;
            pu    <= u + UNIT_W'(rhalf >> 4);
            pl    <= rl - 5'd1;
            ret   <= S_RS_SHR;
            state <= S_PUSH_A;
          end else begin
            state <= S_FIN;
          end
        end
        S_RS_MOVE: begin
          ai    <= alvl;
          state <= S_AL_SRCH;
        end
        S_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {3'b000, largest, reqt, freet, moved, raddr_res, st};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
